[rtl/itma_pkg.sv]
// itma_pkg: widths, codes, constants and shared types for the interval timer
// with windowed mean. No dependencies.
package itma_pkg;

  // field and register widths
  localparam int TS_W      = 64;
  localparam int TPS_W     = 32;
  localparam int WL_W      = 7;
  localparam int SPAN_W    = 31;
  localparam int AVG_W     = 39;
  localparam int SUM_W     = 37;
  localparam int FRAC_BITS = 8;
  localparam int LEN_W     = 8;
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;

  // shared divider
  localparam int DVD_W = 64;
  localparam int DVS_W = 32;
  localparam int PROD_W = 52;

  localparam int DEFAULT_MAX_WINDOW = 64;

  // command codes
  localparam logic [1:0] CMD_START     = 2'd0;
  localparam logic [1:0] CMD_STOP      = 2'd1;
  localparam logic [1:0] CMD_RESET_ALL = 2'd2;
  localparam logic [1:0] CMD_RESET_RUN = 2'd3;

  // register index (paddr[2])
  localparam logic REG_TPS = 1'b0;
  localparam logic REG_WL  = 1'b1;

  localparam logic [TPS_W-1:0]  TPS_RESET      = 32'd10000000;
  localparam logic [WL_W-1:0]   WL_RESET       = 7'd10;
  localparam logic [LEN_W-1:0]  DEFAULT_WINDOW = 8'd10;

  localparam logic [19:0]       US_PER_S  = 20'd1000000;
  localparam logic [SPAN_W-1:0] SPAN_MAX  = {SPAN_W{1'b1}};
  localparam logic [AVG_W-1:0]  AVG_MAX   = {AVG_W{1'b1}};
  // largest whole second count that cannot saturate on its own
  localparam int                WHOLE_MAX = 2147;
  localparam int                WHOLE_W   = 12;

  typedef struct packed {
    logic clear;
    logic shift;
  } cell_ctrl_t;

endpackage

[rtl/interval_timer_moving_average.sv]
// interval_timer_moving_average: top level; uses itma_pkg, itma_cell, itma_div.
// Start, status reset and full reset transactions complete in the idle state. A
// stop while running drives one shared 64-step divider: it turns ticks into
// whole seconds, then (unless the span saturates) the sub-second microseconds,
// then gives the windowed mean; between these the history ring of MAX_WINDOW
// cells rotates once to swap in the new span. A finished result waits in an
// output register while the next command is taken. Configuration goes
// through a small APB port (tick rate at 0x0, window length at 0x4) and must
// only be written while no stop is in flight.
module interval_timer_moving_average import itma_pkg::*; #(
  parameter int MAX_WINDOW = DEFAULT_MAX_WINDOW
) (
  input  logic              clk,
  input  logic              rst,
  // command channel
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  logic [1:0]        command,
  input  logic [TS_W-1:0]   timestamp,
  // result channel
  output logic              res_valid,
  input  logic              res_ready,
  output logic [SPAN_W-1:0] span_us,
  output logic [AVG_W-1:0]  average_q8,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_DIV_SPAN = 9'b000000010,
    S_MUL      = 9'b000000100,
    S_DIV_FRAC = 9'b000001000,
    S_PASS     = 9'b000010000,
    S_SUM      = 9'b000100000,
    S_DIV_AVG  = 9'b001000000,
    S_OUT      = 9'b010000000,
    S_HOLD     = 9'b100000000
  } state_t;

  state_t state;

  // configuration registers
  logic [TPS_W-1:0] tps;
  logic [WL_W-1:0]  wl;

  // timer state
  logic [TS_W-1:0]   start_time;
  logic              running;
  logic              needs_prefill;
  logic [SLOT_W-1:0] write_slot;
  logic [SUM_W-1:0]  window_sum;

  // working registers
  logic [SPAN_W-1:0] span;
  logic [SPAN_W-1:0] old_span;
  logic [31:0]       whole_us;
  logic [PROD_W-1:0] prod;
  logic [SLOT_W-1:0] pass_cnt;

  // divider
  logic             div_start;
  logic [DVD_W-1:0] div_dvd;
  logic [DVS_W-1:0] div_dvs;
  logic             div_busy;
  logic             div_done;
  logic [DVD_W-1:0] div_quo;
  logic [DVS_W-1:0] div_rem;

  // history ring
  cell_ctrl_t        cell_ctrl;
  logic [SPAN_W-1:0] cell_val [MAX_WINDOW];
  logic [SPAN_W-1:0] tail;

  logic              cmd_fire;
  logic              stop_go;
  logic [TPS_W-1:0]  freq;
  logic [LEN_W-1:0]  len_raw;
  logic [LEN_W-1:0]  len8;
  logic [SLOT_W-1:0] slot_eff;
  logic [LEN_W-1:0]  slot_inc;
  logic [SLOT_W-1:0] slot_next;
  logic              pass_hit;
  logic              pass_fill;
  logic              pass_last;
  logic [31:0]       us_total;
  logic [SUM_W+1:0]  fill_sum;
  logic [SUM_W-1:0]  upd_sum;
  logic [SUM_W-1:0]  new_sum;
  logic              out_free;

  assign cmd_ready = (state == S_IDLE);
  assign cmd_fire  = cmd_valid && cmd_ready;
  assign stop_go   = cmd_fire && (command == CMD_STOP) && running;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_WL) ? {{(DATA_W-WL_W){1'b0}}, wl} : tps;

  always_ff @(posedge clk) begin
    if (rst) begin
      tps <= TPS_RESET;
      wl  <= WL_RESET;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_WL) begin
        wl <= pwdata[WL_W-1:0];
      end else begin
        tps <= pwdata;
      end
    end
  end

  assign freq    = (tps == '0) ? TPS_W'(1) : tps;
  assign len_raw = (wl == '0) ? DEFAULT_WINDOW : LEN_W'(wl);
  assign len8    = (len_raw > LEN_W'(MAX_WINDOW)) ? LEN_W'(MAX_WINDOW) : len_raw;

  // slot outside the current window falls back to the first entry
  assign slot_eff  = (LEN_W'(write_slot) >= len8) ? '0 : write_slot;
  assign slot_inc  = LEN_W'(slot_eff) + 1'b1;
  assign slot_next = (slot_inc >= len8) ? '0 : slot_inc[SLOT_W-1:0];

  // ---------------- divider ----------------
  always_comb begin
    div_start = 1'b0;
    div_dvd   = timestamp - start_time;
    div_dvs   = freq;
    case (state)
      S_IDLE: begin
        div_start = stop_go;
      end
      S_MUL: begin
        div_start = 1'b1;
        div_dvd   = DVD_W'(prod);
      end
      S_SUM: begin
        div_start = 1'b1;
        div_dvd   = DVD_W'({new_sum, {FRAC_BITS{1'b0}}});
        div_dvs   = DVS_W'(len8);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  itma_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dvd),
    .divisor   (div_dvs),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // ---------------- history ring ----------------
  assign cell_ctrl.clear = cmd_fire && (command == CMD_RESET_ALL);
  assign cell_ctrl.shift = (state == S_PASS);

  assign pass_hit  = (pass_cnt == slot_eff);
  assign pass_fill = needs_prefill && (LEN_W'(pass_cnt) < len8);
  assign pass_last = (pass_cnt == SLOT_W'(MAX_WINDOW - 1));
  // head leaves cell 0 and re-enters at the far end, replaced where due
  assign tail      = (pass_fill || pass_hit) ? span : cell_val[0];

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    if (i == MAX_WINDOW - 1) begin : g_end
      itma_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .ctrl  (cell_ctrl),
        .nbr   (tail),
        .value (cell_val[i])
      );
    end else begin : g_mid
      itma_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .ctrl  (cell_ctrl),
        .nbr   (cell_val[i+1]),
        .value (cell_val[i])
      );
    end
  end

  // ---------------- arithmetic ----------------
  assign us_total = whole_us + div_quo[31:0];
  assign fill_sum = (SUM_W+2)'(span) * (SUM_W+2)'(len8);
  assign upd_sum  = window_sum + SUM_W'(span) - SUM_W'(old_span);
  assign new_sum  = needs_prefill ? fill_sum[SUM_W-1:0] : upd_sum;
  assign out_free = !res_valid || res_ready;

  // ---------------- control ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      running       <= 1'b0;
      needs_prefill <= 1'b1;
      write_slot    <= '0;
      window_sum    <= '0;
      start_time    <= '0;
      pass_cnt      <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd_fire) begin
            case (command)
              CMD_START: begin
                start_time <= timestamp;
                running    <= 1'b1;
              end
              CMD_STOP: begin
                if (running) begin
                  running <= 1'b0;
                  state   <= S_DIV_SPAN;
                end
              end
              CMD_RESET_ALL: begin
                window_sum    <= '0;
                needs_prefill <= 1'b1;
              end
              default: begin
                running <= 1'b0;
              end
            endcase
          end
        end
        S_DIV_SPAN: begin
          if (div_done) begin
            pass_cnt <= '0;
            if (div_quo > DVD_W'(WHOLE_MAX)) begin
              state <= S_PASS;
            end else begin
              state <= S_MUL;
            end
          end
        end
        S_MUL: begin
          state <= S_DIV_FRAC;
        end
        S_DIV_FRAC: begin
          if (div_done) begin
            state <= S_PASS;
          end
        end
        S_PASS: begin
          pass_cnt <= pass_cnt + 1'b1;
          if (pass_last) begin
            state <= S_SUM;
          end
        end
        S_SUM: begin
          window_sum    <= new_sum;
          needs_prefill <= 1'b0;
          write_slot    <= slot_next;
          state         <= S_DIV_AVG;
        end
        S_DIV_AVG: begin
          if (div_done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end else begin
            state <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // span, working products and the replaced entry
  always_ff @(posedge clk) begin
    if (state == S_DIV_SPAN && div_done) begin
      span     <= SPAN_MAX;
      whole_us <= 32'(div_quo[WHOLE_W-1:0]) * 32'(US_PER_S);
      prod     <= PROD_W'(div_rem) * PROD_W'(US_PER_S);
    end
    if (state == S_DIV_FRAC && div_done) begin
      span <= (us_total > 32'(SPAN_MAX)) ? SPAN_MAX : us_total[SPAN_W-1:0];
    end
    if (state == S_PASS && pass_hit) begin
      old_span <= cell_val[0];
    end
  end

  // result register; the quotient stays put in the divider until the next start
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if ((state == S_OUT || state == S_HOLD) && out_free) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_OUT || state == S_HOLD) && out_free) begin
      span_us    <= span;
      average_q8 <= (div_quo[DVD_W-1:AVG_W] != '0) ? AVG_MAX : div_quo[AVG_W-1:0];
    end
  end

`ifndef SYNTH
  a_res_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> ($past(state == S_OUT) || $past(state == S_HOLD)))
    else $error("result raised outside the output step");

  a_idle_div_quiet: assert property (@(posedge clk) disable iff (rst)
    cmd_ready |-> !div_busy)
    else $error("command taken while the divider is busy");

  a_stop_clears_run: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready && command == CMD_STOP) |=> !running)
    else $error("running still set after a stop transaction");

  a_pass_to_sum: assert property (@(posedge clk) disable iff (rst)
    (state == S_PASS && pass_last) |=> (state == S_SUM && pass_cnt == '0))
    else $error("ring rotation did not end back in place");
`endif

endmodule

[rtl/itma_cell.sv]
// itma_cell: one entry of the span history ring.
// Depends on itma_pkg.
module itma_cell import itma_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cell_ctrl_t        ctrl,
  input  logic [SPAN_W-1:0] nbr,
  output logic [SPAN_W-1:0] value
);

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      value <= '0;
    end else if (ctrl.shift) begin
      value <= nbr;
    end
  end

endmodule

[rtl/itma_div.sv]
// itma_div: restoring divider, one quotient bit per cycle.
// Depends on itma_pkg.
module itma_div import itma_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [DVD_W-1:0] quotient,
  output logic [DVS_W-1:0] remainder
);

  localparam int CNT_W = $clog2(DVD_W);

  logic [DVS_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic [DVS_W:0]   trial;
  logic [DVS_W+1:0] diff;

  assign trial = {remainder, quotient[DVD_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvs       <= divisor;
      remainder <= '0;
      quotient  <= dividend;
    end else if (busy) begin
      if (!diff[DVS_W+1]) begin
        remainder <= diff[DVS_W-1:0];
        quotient  <= {quotient[DVD_W-2:0], 1'b1};
      end else begin
        remainder <= trial[DVS_W-1:0];
        quotient  <= {quotient[DVD_W-2:0], 1'b0};
      end
    end
  end

endmodule

[dv/tb_interval_timer_moving_average.sv]
`timescale 1ns / 1ps
// Testbench for interval_timer_moving_average: directed table, then random phases
// under several tick rates and window lengths. Depends on itma_pkg and the RTL.
module tb_interval_timer_moving_average;
  import itma_pkg::*;

  localparam int STOP_CYCLES = 3 * 64 + DEFAULT_MAX_WINDOW + 6;
  localparam int SETTLE_CYCLES = STOP_CYCLES + 40;
  localparam int HOLD_CYCLES = 2000;
  localparam int IDLE_PCT = 19;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 128;
  localparam logic [63:0] US_SCALE = 64'd1000000;

  typedef enum logic [1:0] {ROW_CMD, ROW_TPS, ROW_WL} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [1:0]  cmd;
    logic [63:0] val;
    logic        typed;
    logic [SPAN_W-1:0] span;
    logic [AVG_W-1:0]  avg;
  } dir_row_t;

  typedef struct packed {
    logic [SPAN_W-1:0] span;
    logic [AVG_W-1:0]  avg;
  } mean_result_t;

  localparam int DIR_ROWS = 32;
  localparam logic [63:0] TS_ALL = {TS_W{1'b1}};

  // expected values typed in only where they are obvious
  dir_row_t dir_tab [DIR_ROWS] = '{
    '{ROW_CMD, CMD_STOP,      64'd5,                 1'b0, '0, '0},
    '{ROW_CMD, CMD_START,     64'd0,                 1'b0, '0, '0},
    '{ROW_CMD, CMD_STOP,      64'd10_000_000,        1'b1, 31'd1000000, 39'd256000000},
    '{ROW_CMD, CMD_START,     64'd100,               1'b0, '0, '0},
    '{ROW_CMD, CMD_RESET_RUN, 64'd150,               1'b0, '0, '0},
    '{ROW_CMD, CMD_STOP,      64'd200,               1'b0, '0, '0},
    '{ROW_CMD, CMD_START,     64'hFFFF_FFFF_FFFF_FFF0, 1'b0, '0, '0},
    '{ROW_CMD, CMD_STOP,      64'd10,                1'b0, '0, '0},
    '{ROW_CMD, CMD_START,     64'd0,                 1'b0, '0, '0},
    '{ROW_CMD, CMD_STOP,      TS_ALL,                1'b0, '0, '0},
    '{ROW_CMD, CMD_RESET_ALL, TS_ALL,                1'b0, '0, '0},
    '{ROW_CMD, CMD_START,     64'd5,                 1'b0, '0, '0},
    '{ROW_CMD, CMD_STOP,      64'd5,                 1'b1, '0, '0},
    '{ROW_TPS, CMD_START,     64'd0,                 1'b0, '0, '0},
    '{ROW_WL,  CMD_START,     64'd0,                 1'b0, '0, '0},
    '{ROW_CMD, CMD_START,     64'd0,                 1'b0, '0, '0},
    '{ROW_CMD, CMD_STOP,      64'd2148,              1'b0, '0, '0},
    '{ROW_TPS, CMD_START,     64'hFFFF_FFFF,         1'b0, '0, '0},
    '{ROW_WL,  CMD_START,     64'd127,               1'b0, '0, '0},
    '{ROW_CMD, CMD_RESET_ALL, 64'd0,                 1'b0, '0, '0},
    '{ROW_CMD, CMD_START,     64'd0,                 1'b0, '0, '0},
    '{ROW_CMD, CMD_STOP,      64'hFFFF_FFFF,         1'b1, 31'd1000000, 39'd256000000},
    '{ROW_TPS, CMD_START,     64'd1,                 1'b0, '0, '0},
    '{ROW_CMD, CMD_RESET_ALL, 64'd0,                 1'b0, '0, '0},
    '{ROW_CMD, CMD_START,     64'd0,                 1'b0, '0, '0},
    '{ROW_CMD, CMD_STOP,      64'd3000,              1'b1, SPAN_MAX, {SPAN_MAX, 8'h00}},
    '{ROW_WL,  CMD_START,     64'd1,                 1'b0, '0, '0},
    '{ROW_CMD, CMD_START,     64'd0,                 1'b0, '0, '0},
    '{ROW_CMD, CMD_STOP,      64'd0,                 1'b1, '0, AVG_MAX},
    '{ROW_WL,  CMD_START,     64'd10,                1'b0, '0, '0},
    '{ROW_TPS, CMD_START,     64'd10_000_000,        1'b0, '0, '0},
    '{ROW_CMD, CMD_RESET_ALL, 64'd0,                 1'b0, '0, '0}
  };

  logic              clk;
  logic              rst;
  logic              cmd_valid;
  logic              cmd_ready;
  logic [1:0]        command;
  logic [TS_W-1:0]   timestamp;
  logic              res_valid;
  logic              res_ready;
  logic [SPAN_W-1:0] span_us;
  logic [AVG_W-1:0]  average_q8;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  // shadow of the block's registers and state
  logic [TPS_W-1:0]  cfg_tps = TPS_RESET;
  logic [WL_W-1:0]   cfg_wlen = WL_RESET;
  logic [TS_W-1:0]   mark_ts = '0;
  logic              timing = 1'b0;
  logic              prefill_due = 1'b1;
  logic [SPAN_W-1:0] span_ring [DEFAULT_MAX_WINDOW] = '{default: '0};
  logic [5:0]        ring_slot = '0;
  logic [SUM_W-1:0]  ring_sum = '0;

  mean_result_t pending_means[$];
  int  fail_count = 0;
  bit  steady = 1'b0;
  bit  hold_req = 1'b0;
  bit  hold_done = 1'b0;
  logic              dir_exp_on = 1'b0;
  logic [SPAN_W-1:0] dir_span = '0;
  logic [AVG_W-1:0]  dir_avg = '0;

  interval_timer_moving_average DUT (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .command    (command),
    .timestamp  (timestamp),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .span_us    (span_us),
    .average_q8 (average_q8),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic int unsigned active_len();
    int unsigned len;
    len = cfg_wlen;
    if (len == 0) len = DEFAULT_WINDOW;
    if (len > DEFAULT_MAX_WINDOW) len = DEFAULT_MAX_WINDOW;
    return len;
  endfunction

  function automatic logic [SPAN_W-1:0] ticks_to_span(input logic [63:0] ticks);
    logic [63:0] freq;
    logic [63:0] whole;
    logic [63:0] rest;
    logic [63:0] us;
    freq = {32'd0, cfg_tps};
    if (freq == 0) freq = 64'd1;
    whole = ticks / freq;
    rest = ticks % freq;
    if (whole > WHOLE_MAX) return SPAN_MAX;
    us = whole * US_SCALE + (rest * US_SCALE) / freq;
    return (us > {33'd0, SPAN_MAX}) ? SPAN_MAX : us[SPAN_W-1:0];
  endfunction

  // advances the shadow state by one command; returns 1 when a result is due
  function automatic bit timer_step(input logic [1:0] cmd, input logic [63:0] ts,
                                    output logic [SPAN_W-1:0] sp,
                                    output logic [AVG_W-1:0] av);
    int unsigned len;
    int unsigned slot;
    logic [63:0] wide;
    sp = '0;
    av = '0;
    case (cmd)
      CMD_START: begin
        mark_ts = ts;
        timing = 1'b1;
        return 1'b0;
      end
      CMD_RESET_ALL: begin
        for (int i = 0; i < DEFAULT_MAX_WINDOW; i++) span_ring[i] = '0;
        ring_sum = '0;
        prefill_due = 1'b1;
        return 1'b0;
      end
      CMD_RESET_RUN: begin
        timing = 1'b0;
        return 1'b0;
      end
      default: ;
    endcase
    if (!timing) return 1'b0;
    timing = 1'b0;
    sp = ticks_to_span(ts - mark_ts);
    len = active_len();
    if (prefill_due) begin
      prefill_due = 1'b0;
      for (int i = 0; i < len; i++) span_ring[i] = sp;
      wide = {33'd0, sp} * 64'(len);
      ring_sum = wide[SUM_W-1:0];
    end
    slot = ring_slot;
    if (slot >= len) slot = 0;
    ring_sum = ring_sum + sp - span_ring[slot];
    span_ring[slot] = sp;
    slot++;
    if (slot >= len) slot = 0;
    ring_slot = slot[5:0];
    wide = ({27'd0, ring_sum} << FRAC_BITS) / 64'(len);
    av = (wide > {25'd0, AVG_MAX}) ? AVG_MAX : wide[AVG_W-1:0];
    return 1'b1;
  endfunction

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%0t: %s", $realtime, msg);
  endfunction

  // results are checked before the command of the same edge is predicted
  always @(posedge clk) begin
    mean_result_t exp_res;
    logic [SPAN_W-1:0] sp;
    logic [AVG_W-1:0] av;
    bit got;
    if (rst === 1'b0) begin
      if (res_valid && res_ready) begin
        if (pending_means.size() == 0) begin
          note_failure($sformatf("result span %0d mean %0d with nothing pending",
                                 span_us, average_q8));
        end else begin
          exp_res = pending_means.pop_front();
          if (exp_res.span !== span_us || exp_res.avg !== average_q8)
            note_failure($sformatf("span_us exp %0d got %0d, average_q8 exp %0d got %0d",
                                   exp_res.span, span_us, exp_res.avg, average_q8));
        end
      end
      if (cmd_valid && cmd_ready) begin
        got = timer_step(command, timestamp, sp, av);
        if (dir_exp_on) pending_means.push_back('{dir_span, dir_avg});
        else if (got) pending_means.push_back('{sp, av});
      end
    end
  end

  // result side: random stalls, one long hold-off while commands keep coming
  initial begin
    res_ready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        res_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      res_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

  task automatic offer_command(input logic [1:0] c, input logic [63:0] ts,
                               input logic typed = 1'b0,
                               input logic [SPAN_W-1:0] t_span = '0,
                               input logic [AVG_W-1:0] t_avg = '0);
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      cmd_valid <= 1'b0;
      @(negedge clk);
    end
    cmd_valid <= 1'b1;
    command <= c;
    timestamp <= ts;
    dir_exp_on = typed;
    dir_span = t_span;
    dir_avg = t_avg;
    do @(posedge clk); while (!cmd_ready);
  endtask

  // let every outstanding stop finish before touching the registers
  task automatic settle_block();
    @(negedge clk);
    cmd_valid <= 1'b0;
    dir_exp_on = 1'b0;
    while (pending_means.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic reg_sel, input logic [DATA_W-1:0] value);
    logic [DATA_W-1:0] readback;
    readback = (reg_sel == REG_TPS) ? value : {25'd0, value[WL_W-1:0]};
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_sel, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (reg_sel == REG_TPS) cfg_tps = value;
    else cfg_wlen = value[WL_W-1:0];
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== readback)
      note_failure($sformatf("register %0d reads %0h, wrote %0h", reg_sel, prdata, readback));
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    logic [63:0] ts_base;
    logic [63:0] delta;
    logic [63:0] rate;
    logic [DATA_W-1:0] new_tps;
    logic [DATA_W-1:0] new_wl;
    int n;
    int r;
    rst = 1'b1;
    cmd_valid = 1'b0;
    command = CMD_START;
    timestamp = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_ROWS; i++) begin
      case (dir_tab[i].kind)
        ROW_TPS: begin
          settle_block();
          apb_write(REG_TPS, dir_tab[i].val[DATA_W-1:0]);
        end
        ROW_WL: begin
          settle_block();
          apb_write(REG_WL, dir_tab[i].val[DATA_W-1:0]);
        end
        default:
          offer_command(dir_tab[i].cmd, dir_tab[i].val, dir_tab[i].typed,
                        dir_tab[i].span, dir_tab[i].avg);
      endcase
    end

    ts_base = {$urandom, $urandom};
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin new_tps = 32'd1000;        new_wl = 32'd1;  end
        1: begin new_tps = 32'd10_000_000;  new_wl = 32'd64; end
        2: begin new_tps = 32'hFFFF_FFFF;   new_wl = 32'd10; end
        3: begin new_tps = 32'd1;           new_wl = 32'd2;  end
        4: begin new_tps = 32'd27_000_000;  new_wl = 32'd33; end
        5: begin new_tps = 32'd0;           new_wl = 32'd0;  end
        default: begin
          new_tps = $urandom;
          new_wl = $urandom_range(0, 127);
        end
      endcase
      settle_block();
      apb_write(REG_TPS, new_tps);
      apb_write(REG_WL, new_wl);
      steady = (p == 3);
      if (p == 1) hold_req = 1'b1;
      // some phases keep the old history across a window change
      if (p % 3 != 2) offer_command(CMD_RESET_ALL, {$urandom, $urandom});
      rate = (cfg_tps == 0) ? 64'd1 : {32'd0, cfg_tps};
      n = 0;
      while (n < PHASE_ITEMS) begin
        r = $urandom_range(0, 99);
        if (r < 80) begin
          ts_base = ts_base + 64'($urandom_range(0, 1_000_000));
          if ($urandom_range(0, 19) == 0) ts_base = {$urandom, $urandom};
          case ($urandom_range(0, 9))
            0, 1, 2, 3: delta = {$urandom, $urandom} % (rate * 3 + 1);
            4, 5:       delta = 64'($urandom_range(0, 1000));
            6:          delta = {$urandom, $urandom};
            7:          delta = 64'($urandom) << $urandom_range(0, 31);
            default:    delta = {$urandom, $urandom} % (rate * 2200 + 1);
          endcase
          offer_command(CMD_START, ts_base);
          offer_command(CMD_STOP, ts_base + delta);
          n += 2;
        end else if (r < 84) begin
          offer_command(CMD_RESET_ALL, {$urandom, $urandom});
          n++;
        end else if (r < 88) begin
          offer_command(CMD_RESET_RUN, {$urandom, $urandom});
          n++;
        end else begin
          offer_command(2'($urandom_range(0, 3)), {$urandom, $urandom});
          n++;
        end
      end
      steady = 1'b0;
    end

    settle_block();
    if (fail_count == 0 && pending_means.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
